// ===== hw/rtl/arc_cache_replacement_core_assert.svh =====
// assertion macros for the arc directory core
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ARC_CACHE_REPLACEMENT_CORE_ASSERT_SVH
`define ARC_CACHE_REPLACEMENT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ARC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("arc core check failed");
`define ARC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("arc core check failed");
`else
`define ARC_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define ARC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hw/rtl/arcrep_pkg.sv =====
// shared types and codes for the arc replacement directory
// no dependencies
package arcrep_pkg;

  // resident slots; the slot and capacity port widths are sized for this
  localparam int CACHE_SLOTS = 64;

  typedef enum logic [2:0] {
    L_NONE = 3'd0,
    L_T1   = 3'd1,
    L_T2   = 3'd2,
    L_B1   = 3'd3,
    L_B2   = 3'd4
  } list_code_t;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_REPLACE = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  typedef enum logic [2:0] {
    OP_UNE   = 3'd0,
    OP_DROP  = 3'd1,
    OP_EVICT = 3'd2,
    OP_HIT   = 3'd3,
    OP_NEW   = 3'd4
  } op_t;

  // per-field write enables of the directory memory
  typedef struct packed {
    logic key;
    logic list;
    logic dirty;
    logic slot;
    logic older;
    logic newer;
  } entry_we_t;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_SCAN     = 15'b000000000000010,
    S_SCAN_END = 15'b000000000000100,
    S_PREP     = 15'b000000000001000,
    S_DIV      = 15'b000000000010000,
    S_PLAN     = 15'b000000000100000,
    S_CHECK    = 15'b000000001000000,
    S_UL_RD    = 15'b000000010000000,
    S_UL_HEAD  = 15'b000000100000000,
    S_UL_TAIL  = 15'b000001000000000,
    S_UL_CLR   = 15'b000010000000000,
    S_PU_LINK  = 15'b000100000000000,
    S_PU_TAIL  = 15'b001000000000000,
    S_DONE     = 15'b010000000000000,
    S_SPARE    = 15'b100000000000000
  } state_t;

  // list code to index of the head, tail and length registers
  function automatic logic [1:0] list_sel(input list_code_t l);
    logic [2:0] d;
    d = l - L_T1;
    return d[1:0];
  endfunction

endpackage

// ===== hw/rtl/arc_cache_replacement_core.sv =====
// arc cache directory: one access request at a time; the result is held in the output register.
// the key search reads one directory entry per cycle through the single read port; a ghost hit
// adds a bit-serial divide before the list updates.
// reset is synchronous: lists empty, target zero, all slots free, no clearing pass.
`include "arc_cache_replacement_core_assert.svh"

module arc_cache_replacement_core #(
  parameter int KEY_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cache_blocks_used,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] block_key,
  input  logic        is_write,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  cache_slot,
  output logic [31:0] evicted_key,
  output logic        evicted_dirty
);
  import arcrep_pkg::*;

  localparam int ENTRIES = 2 * CACHE_SLOTS;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = $clog2(CACHE_SLOTS);
  localparam int LEN_W   = $clog2(ENTRIES + 1);
  localparam int LW1     = LEN_W + 1;
  localparam int CNT_W   = $clog2(CACHE_SLOTS + 1);
  localparam int DCNT_W  = $clog2(LEN_W);
  localparam int TOT_W   = LEN_W + 2;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    list_code_t          list;
    logic                dirty;
    logic [SLOT_W-1:0]   slot;
    logic [IDX_W-1:0]    older;
    logic [IDX_W-1:0]    newer;
  } entry_t;

  // directory memory
  entry_t           dir_mem [ENTRIES];
  entry_t           rdata;
  entry_we_t        we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  state_t state;
  op_t    op;

  logic [6:0]          cfg_reg;
  logic [CNT_W-1:0]    c_reg;
  logic [CNT_W-1:0]    p_reg;
  logic [KEY_BITS-1:0] key_reg;
  logic                wr_reg;

  logic [ENTRIES-1:0]     ent_valid;
  logic [CACHE_SLOTS-1:0] slot_free;
  logic [IDX_W-1:0]       list_head [4];
  logic [IDX_W-1:0]       list_tail [4];
  logic [LEN_W-1:0]       list_len [4];

  // scan
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  chk_idx;
  logic              chk_vld;
  logic              e_found;
  logic [IDX_W-1:0]  e_idx;
  list_code_t        loc;
  logic              emp_found;
  logic [IDX_W-1:0]  emp_idx;
  logic              ff_found;
  logic [SLOT_W-1:0] ff_slot;
  logic              chk_empty;

  // divider
  logic [LEN_W-1:0]  div_num;
  logic [LEN_W-1:0]  div_den;
  logic [LEN_W-1:0]  div_rem;
  logic [LEN_W-1:0]  div_quo;
  logic [DCNT_W-1:0] div_cnt;
  logic [LW1-1:0]    div_trial;
  logic              div_ge;

  // plan
  logic [LW1-1:0] t1w, t2w, b1w, b2w, cw, pw, sum, pn, l1, l2;
  logic [LEN_W-1:0] rr;
  list_code_t plan_cache, plan_meta;
  logic       plan_ghost, plan_hit, plan_fail1, repl;
  list_code_t pl_cache, pl_meta;
  logic       pl_ghost, pl_hit, pl_fail1;
  logic [CNT_W-1:0] pl_p;

  // check
  logic             ev_in, drop_c, evf, slot_fail, ent_fail, chk_fail;
  logic [IDX_W-1:0] drop_idx, evf_idx, cand_idx, new_idx_c;
  logic             cand_vld;
  logic [SLOT_W-1:0] new_slot_c;
  logic [1:0]       status_c;
  op_t              first_op, go_op;

  logic              drop_pend;
  logic [IDX_W-1:0]  new_idx;
  logic [SLOT_W-1:0] new_slot;
  list_code_t        ne_list;

  // list operations
  logic [IDX_W-1:0] tgt, ul_target;
  logic [IDX_W-1:0] push_idx;
  list_code_t       push_list;
  logic [1:0]       rd_k, pk;
  logic             hit_dirty;

  logic [1:0]  res_status;
  logic [5:0]  res_slot;
  logic [31:0] res_ev_key;
  logic        res_ev_dirty;

  logic [TOT_W-1:0] len_total;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign rd_k      = list_sel(rdata.list);
  assign pk        = list_sel(push_list);
  assign chk_empty = !ent_valid[chk_idx] || rdata.list == L_NONE;

  // divider step
  assign div_trial = {div_rem, div_num[LEN_W-1]};
  assign div_ge    = div_trial >= LW1'(div_den);

  // replacement decision
  always_comb begin
    t1w = LW1'(list_len[0]);
    t2w = LW1'(list_len[1]);
    b1w = LW1'(list_len[2]);
    b2w = LW1'(list_len[3]);
    cw  = LW1'(c_reg);
    pw  = LW1'(p_reg);
    rr  = (div_den == '0 || div_quo == '0) ? LEN_W'(1) : div_quo;
    sum = pw + LW1'(rr);
    pn  = pw;
    if (e_found && loc == L_B1) begin
      pn = (sum < cw) ? sum : cw;
    end else if (e_found && loc == L_B2) begin
      pn = (pw > LW1'(rr)) ? pw - LW1'(rr) : '0;
    end
    l1 = t1w + b1w;
    l2 = t2w + b2w;
    plan_cache = L_NONE;
    plan_meta  = L_NONE;
    plan_ghost = 1'b0;
    repl       = 1'b0;
    plan_hit   = e_found && (loc == L_T1 || loc == L_T2);
    if (plan_hit) begin
      repl = 1'b0;
    end else if (e_found) begin
      repl = 1'b1;
    end else if (l1 == cw) begin
      if (t1w < cw) begin
        plan_meta = L_B1;
        repl      = 1'b1;
      end else begin
        plan_cache = L_T1;
      end
    end else if (l1 < cw && (l1 + l2) >= cw) begin
      if ((l1 + l2) == (cw << 1)) begin
        plan_meta = L_B2;
      end
      repl = 1'b1;
    end
    if (repl) begin
      if (t1w != '0 && ((loc == L_B2 && t1w == pn) || t1w > pn)) begin
        plan_cache = L_T1;
        plan_ghost = 1'b1;
      end else begin
        plan_cache = L_T2;
      end
    end
    plan_fail1 = plan_cache != L_NONE && list_len[list_sel(plan_cache)] == '0;
  end

  // fail checks, new entry and slot choice; rdata holds the victim entry here
  always_comb begin
    ev_in    = pl_cache != L_NONE && CNT_W'(rdata.slot) < c_reg;
    drop_c   = pl_meta != L_NONE && list_len[list_sel(pl_meta)] != '0;
    drop_idx = list_head[list_sel(pl_meta)];
    evf      = pl_cache == L_T1 && !pl_ghost;
    evf_idx  = list_head[list_sel(pl_cache)];
    slot_fail = !pl_hit && !ff_found && !ev_in;
    ent_fail  = !pl_hit && !e_found && !emp_found && !drop_c && !evf;
    chk_fail  = pl_fail1 || slot_fail || ent_fail;
    cand_idx = emp_idx;
    cand_vld = emp_found;
    if (drop_c && (!cand_vld || drop_idx < cand_idx)) begin
      cand_idx = drop_idx;
      cand_vld = 1'b1;
    end
    if (evf && (!cand_vld || evf_idx < cand_idx)) begin
      cand_idx = evf_idx;
      cand_vld = 1'b1;
    end
    new_idx_c  = e_found ? e_idx : cand_idx;
    new_slot_c = (ff_found && (!ev_in || ff_slot < rdata.slot)) ? ff_slot : rdata.slot;
    status_c   = pl_hit ? ST_HIT : (pl_cache != L_NONE ? ST_REPLACE : ST_NEW);
    if (pl_hit) begin
      first_op = OP_HIT;
    end else if (e_found) begin
      first_op = OP_UNE;
    end else if (drop_c) begin
      first_op = OP_DROP;
    end else if (pl_cache != L_NONE) begin
      first_op = OP_EVICT;
    end else begin
      first_op = OP_NEW;
    end
  end

  always_comb begin
    case (op)
      OP_UNE:  go_op = drop_pend ? OP_DROP : (pl_cache != L_NONE ? OP_EVICT : OP_NEW);
      OP_DROP: go_op = (pl_cache != L_NONE) ? OP_EVICT : OP_NEW;
      default: go_op = OP_NEW;
    endcase
  end

  always_comb begin
    case (op)
      OP_DROP:  ul_target = list_head[list_sel(pl_meta)];
      OP_EVICT: ul_target = list_head[list_sel(pl_cache)];
      default:  ul_target = e_idx;
    endcase
  end

  // directory memory port control
  always_comb begin
    we      = '0;
    wa      = '0;
    wd      = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_idx;
      end
      S_PLAN: begin
        rd_en   = plan_cache != L_NONE;
        rd_addr = list_head[list_sel(plan_cache)];
      end
      S_UL_RD: begin
        rd_en   = 1'b1;
        rd_addr = ul_target;
      end
      S_UL_HEAD: begin
        if (list_head[rd_k] != tgt) begin
          we.newer = 1'b1;
          wa       = rdata.older;
          wd.newer = rdata.newer;
        end
      end
      S_UL_TAIL: begin
        if (list_tail[rd_k] != tgt) begin
          we.older = 1'b1;
          wa       = rdata.newer;
          wd.older = rdata.older;
        end
      end
      S_UL_CLR: begin
        we.list  = 1'b1;
        we.dirty = 1'b1;
        wa       = tgt;
        wd.list  = L_NONE;
        wd.dirty = 1'b0;
      end
      S_PU_LINK: begin
        if (list_len[pk] != '0) begin
          we.newer = 1'b1;
          wa       = list_tail[pk];
          wd.newer = push_idx;
        end
      end
      S_PU_TAIL: begin
        we.older = 1'b1;
        we.list  = 1'b1;
        wa       = push_idx;
        wd.older = list_tail[pk];
        wd.list  = push_list;
        if (op == OP_HIT) begin
          we.dirty = 1'b1;
          wd.dirty = hit_dirty | wr_reg;
        end else if (op == OP_NEW) begin
          we.dirty = 1'b1;
          we.key   = 1'b1;
          we.slot  = 1'b1;
          wd.dirty = wr_reg;
          wd.key   = key_reg;
          wd.slot  = new_slot;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we.key)   dir_mem[wa].key   <= wd.key;
    if (we.list)  dir_mem[wa].list  <= wd.list;
    if (we.dirty) dir_mem[wa].dirty <= wd.dirty;
    if (we.slot)  dir_mem[wa].slot  <= wd.slot;
    if (we.older) dir_mem[wa].older <= wd.older;
    if (we.newer) dir_mem[wa].newer <= wd.newer;
    if (rd_en) begin
      rdata <= dir_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cfg_reg   <= 7'd64;
      p_reg     <= '0;
      ent_valid <= '0;
      slot_free <= '1;
      chk_vld   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        list_len[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_reg <= cache_blocks_used;
      end

      chk_vld <= (state == S_SCAN);
      chk_idx <= scan_idx;
      if (chk_vld) begin
        if (!chk_empty && rdata.key == key_reg && !e_found) begin
          e_found <= 1'b1;
          e_idx   <= chk_idx;
          loc     <= rdata.list;
        end
        if (chk_empty && !emp_found) begin
          emp_found <= 1'b1;
          emp_idx   <= chk_idx;
        end
        if (chk_idx < IDX_W'(c_reg) && slot_free[chk_idx[SLOT_W-1:0]] && !ff_found) begin
          ff_found <= 1'b1;
          ff_slot  <= chk_idx[SLOT_W-1:0];
        end
      end

      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid     <= 1'b1;
        status        <= res_status;
        cache_slot    <= res_slot;
        evicted_key   <= res_ev_key;
        evicted_dirty <= res_ev_dirty;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_reg   <= KEY_BITS'(block_key);
            wr_reg    <= is_write;
            if (cfg_reg == '0) begin
              c_reg <= CNT_W'(1);
            end else if (int'(cfg_reg) > CACHE_SLOTS) begin
              c_reg <= CNT_W'(CACHE_SLOTS);
            end else begin
              c_reg <= CNT_W'(cfg_reg);
            end
            e_found   <= 1'b0;
            emp_found <= 1'b0;
            ff_found  <= 1'b0;
            loc       <= L_NONE;
            scan_idx  <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == IDX_W'(ENTRIES - 1)) begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          state <= S_PREP;
        end
        S_PREP: begin
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= '0;
          if (e_found && loc == L_B1) begin
            div_num <= list_len[3];
            div_den <= list_len[2];
            state   <= S_DIV;
          end else if (e_found && loc == L_B2) begin
            div_num <= list_len[2];
            div_den <= list_len[3];
            state   <= S_DIV;
          end else begin
            state <= S_PLAN;
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? LEN_W'(div_trial - LW1'(div_den)) : LEN_W'(div_trial);
          div_quo <= {div_quo[LEN_W-2:0], div_ge};
          div_num <= div_num << 1;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(LEN_W - 1)) begin
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          pl_cache <= plan_cache;
          pl_meta  <= plan_meta;
          pl_ghost <= plan_ghost;
          pl_hit   <= plan_hit;
          pl_fail1 <= plan_fail1;
          pl_p     <= CNT_W'(pn);
          state    <= S_CHECK;
        end
        S_CHECK: begin
          res_ev_key   <= '0;
          res_ev_dirty <= 1'b0;
          if (chk_fail) begin
            res_status <= ST_FAIL;
            res_slot   <= '0;
            state      <= S_DONE;
          end else begin
            p_reg      <= pl_p;
            res_status <= status_c;
            res_slot   <= 6'(new_slot_c);
            drop_pend  <= drop_c;
            new_idx    <= new_idx_c;
            new_slot   <= new_slot_c;
            ne_list    <= e_found ? L_T2 : L_T1;
            op         <= first_op;
            push_idx   <= new_idx_c;
            push_list  <= e_found ? L_T2 : L_T1;
            state      <= (first_op == OP_NEW) ? S_PU_LINK : S_UL_RD;
          end
        end
        S_UL_RD: begin
          tgt   <= ul_target;
          state <= S_UL_HEAD;
        end
        S_UL_HEAD: begin
          if (list_head[rd_k] == tgt) begin
            list_head[rd_k] <= rdata.newer;
          end
          if (op == OP_EVICT) begin
            res_ev_key            <= 32'(rdata.key);
            res_ev_dirty          <= rdata.dirty;
            slot_free[rdata.slot] <= 1'b1;
          end
          if (op == OP_HIT) begin
            res_slot  <= 6'(rdata.slot);
            hit_dirty <= rdata.dirty;
          end
          state <= S_UL_TAIL;
        end
        S_UL_TAIL: begin
          if (list_tail[rd_k] == tgt) begin
            list_tail[rd_k] <= rdata.older;
          end
          state <= S_UL_CLR;
        end
        S_UL_CLR: begin
          list_len[rd_k] <= list_len[rd_k] - LEN_W'(1);
          if (op == OP_HIT) begin
            push_idx  <= tgt;
            push_list <= L_T2;
            state     <= S_PU_LINK;
          end else if (op == OP_EVICT && (pl_ghost || pl_cache == L_T2)) begin
            // victim keeps its key as a ghost
            push_idx  <= tgt;
            push_list <= (pl_cache == L_T2) ? L_B2 : L_B1;
            state     <= S_PU_LINK;
          end else begin
            op        <= go_op;
            push_idx  <= new_idx;
            push_list <= ne_list;
            state     <= (go_op == OP_NEW) ? S_PU_LINK : S_UL_RD;
          end
        end
        S_PU_LINK: begin
          if (list_len[pk] == '0) begin
            list_head[pk] <= push_idx;
          end
          state <= S_PU_TAIL;
        end
        S_PU_TAIL: begin
          list_tail[pk]       <= push_idx;
          list_len[pk]        <= list_len[pk] + LEN_W'(1);
          ent_valid[push_idx] <= 1'b1;
          if (op == OP_NEW) begin
            slot_free[new_slot] <= 1'b0;
          end
          if (op == OP_EVICT) begin
            op        <= OP_NEW;
            push_idx  <= new_idx;
            push_list <= ne_list;
            state     <= S_PU_LINK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign len_total = TOT_W'(list_len[0]) + TOT_W'(list_len[1]) +
                     TOT_W'(list_len[2]) + TOT_W'(list_len[3]);

  `ARC_ASSERT_IMPLY(a_dir_bound, clk, rst, 1'b1, len_total <= TOT_W'(ENTRIES))
  `ARC_ASSERT_IMPLY(a_unlink_member, clk, rst, state == S_UL_HEAD, rdata.list != L_NONE)
  `ARC_ASSERT_IMPLY(a_fail_clean, clk, rst, out_valid && status == ST_FAIL, cache_slot == '0 && evicted_key == '0 && !evicted_dirty)
  `ARC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule
